// ===== rtl/utf8_byte_stream_decoder_defines.svh =====
// assertion macros for the utf8 byte stream decoder
`ifndef UTF8_BYTE_STREAM_DECODER_DEFINES_SVH
`define UTF8_BYTE_STREAM_DECODER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define UBSD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ubsd assertion failed");
// next-cycle implication
`define UBSD_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ubsd assertion failed");
`else
`define UBSD_ASSERT_IMP(label, clk, rst, ante, cons)
`define UBSD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/ubsd_pkg.sv =====
package ubsd_pkg;

   // continuation bytes still expected
   localparam logic [1:0] PEND_LEAD = 2'd0;
   localparam logic [1:0] PEND_ONE  = 2'd1;
   localparam logic [1:0] PEND_TWO  = 2'd2;
   localparam logic [1:0] PEND_OVER = 2'd3;

   localparam logic [15:0] QMARK_CODE = 16'h003F;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_end;
   } ubsd_item_type;

   typedef struct packed {
      logic        emit;
      logic [15:0] char_code;
   } ubsd_result_type;

endpackage

// ===== rtl/ubsd_if.sv =====
interface ubsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       buffer_end;

   modport source (output valid, output data_byte, output buffer_end, input ready);
   modport sink (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface ubsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink (input valid, input char_code, output ready);
endinterface

// ===== rtl/ubsd_in_reg.sv =====
module ubsd_in_reg
   import ubsd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   ubsd_req_if.sink      req_bus,
   input  logic          advance,
   output logic          item_valid,
   output ubsd_item_type item
);

   logic          valid_ff, valid_in;
   ubsd_item_type item_ff, item_in;
   logic          take;

   // room whenever the register is empty or the held byte leaves this cycle
   assign req_bus.ready = !valid_ff || advance;
   assign take          = req_bus.valid && req_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (advance) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in           = 1'b1;
         item_in.data_byte  = req_bus.data_byte;
         item_in.buffer_end = req_bus.buffer_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== rtl/ubsd_decode.sv =====
module ubsd_decode
   import ubsd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  ubsd_item_type   item,
   input  logic            advance,
   output ubsd_result_type result,
   output logic [1:0]      pending
);

   logic [1:0] pend_ff, pend_in;
   logic [9:0] part_ff, part_in;
   logic [7:0] b;

   assign b = item.data_byte;

   always_comb begin
      pend_in          = pend_ff;
      part_in          = part_ff;
      result.emit      = 1'b0;
      result.char_code = QMARK_CODE;
      unique case (pend_ff) inside
         PEND_LEAD: begin
            if (!b[7]) begin
               result.emit      = 1'b1;
               result.char_code = {8'h00, b};
            end else if (b[7:6] == 2'b10 || b[7:4] == 4'hF || item.buffer_end) begin
               result.emit = 1'b1;
            end else if (!b[5]) begin
               pend_in = PEND_ONE;
               part_in = {5'd0, b[4:0]};
            end else begin
               pend_in = PEND_TWO;
               part_in = {6'd0, b[3:0]};
            end
         end
         PEND_ONE: begin
            result.emit      = 1'b1;
            result.char_code = {part_ff, b[5:0]};
            pend_in          = PEND_LEAD;
            part_in          = '0;
         end
         PEND_TWO, PEND_OVER: begin
            if (item.buffer_end) begin
               result.emit = 1'b1;
               pend_in     = PEND_LEAD;
               part_in     = '0;
            end else begin
               pend_in = PEND_ONE;
               part_in = {part_ff[3:0], b[5:0]};
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= PEND_LEAD;
         part_ff <= '0;
      end else if (advance) begin
         pend_ff <= pend_in;
         part_ff <= part_in;
      end
   end

   assign pending = pend_ff;

endmodule

// ===== rtl/ubsd_out_reg.sv =====
module ubsd_out_reg
   import ubsd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  ubsd_result_type result,
   output logic            free,
   ubsd_rsp_if.source      rsp_bus
);

   logic        valid_ff, valid_in;
   logic [15:0] code_ff, code_in;

   assign free = !valid_ff || rsp_bus.ready;

   always_comb begin
      valid_in = valid_ff;
      code_in  = code_ff;
      if (valid_ff && rsp_bus.ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         code_in  = result.char_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      code_ff <= code_in;
   end

   assign rsp_bus.valid     = valid_ff;
   assign rsp_bus.char_code = code_ff;

endmodule

// ===== rtl/utf8_byte_stream_decoder.sv =====
// channel   dir  payload                          transfer when
// req_bus   in   data_byte[7:0], buffer_end       valid && ready
// rsp_bus   out  char_code[15:0]                  valid && ready
//
// one byte per cycle sustained unless a stalled result holds a character; it passes the byte then result register
// throughput is set by the single decode step between the byte register and result register
// reset (synchronous) empties both registers and clears the pending count and gathered bits
// a stalled result holds its register; bytes that give no character still move on meanwhile
// a byte that gives a character waits in the byte register until the result register frees
`include "utf8_byte_stream_decoder_defines.svh"

module utf8_byte_stream_decoder
   import ubsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   ubsd_req_if.sink    req_bus,
   ubsd_rsp_if.source  rsp_bus
);

   logic            item_valid;
   ubsd_item_type   item;
   ubsd_result_type result;
   logic [1:0]      pending;
   logic            out_free;
   logic            advance;

   // held byte is decoded and retired; it needs the result register only if it emits
   assign advance = item_valid && (!result.emit || out_free);

   // input byte register, ready follows the retire of the byte it holds
   ubsd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // sequence state and decode of the held byte
   ubsd_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .item    (item),
      .advance (advance),
      .result  (result),
      .pending (pending)
   );

   // result register facing the sink
   ubsd_out_reg u_out_reg (
      .clock   (clock),
      .reset   (reset),
      .load    (advance && result.emit),
      .result  (result),
      .free    (out_free),
      .rsp_bus (rsp_bus)
   );

   // a pending count of three is never produced
   `UBSD_ASSERT_IMP(a_pend_range, clock, reset, 1'b1, pending != PEND_OVER)
   // every emitted character leaves the decoder expecting a lead byte
   `UBSD_ASSERT_NXT(a_emit_clears, clock, reset, advance && result.emit, pending == PEND_LEAD)
   // input back-pressure only comes from a stalled result register
   `UBSD_ASSERT_IMP(a_stall_cause, clock, reset, !req_bus.ready,
                    item_valid && result.emit && rsp_bus.valid && !rsp_bus.ready)

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb
   import ubsd_pkg::*;
();

   // scoreboard: tracks the decoder state and the characters still owed
   class char_scoreboard;
      logic [1:0]  pending_bytes;
      logic [9:0]  gathered_bits;
      logic [15:0] owed_chars[$];
      int          errors;
      int          bytes_seen;
      int          chars_checked;
      int          qmarks_owed;

      function new();
         pending_bytes = PEND_LEAD;
         gathered_bits = '0;
         errors        = 0;
         bytes_seen    = 0;
         chars_checked = 0;
         qmarks_owed   = 0;
      endfunction

      task report(input string msg);
         $display("mismatch: %s", msg);
         errors++;
      endtask

      // one accepted byte; may owe one character
      function void note_byte(input logic [7:0] b, input logic last);
         logic        owes;
         logic [15:0] code;
         owes = 1'b0;
         code = '0;
         bytes_seen++;
         case (pending_bytes)
            PEND_LEAD: begin
               if (b < 8'h80) begin
                  owes = 1'b1;
                  code = {8'h00, b};
               end else if (b < 8'hC0 || b >= 8'hF0 || last) begin
                  owes = 1'b1;
                  code = QMARK_CODE;
               end else if (b < 8'hE0) begin
                  gathered_bits = {5'b0, b[4:0]};
                  pending_bytes = PEND_ONE;
               end else begin
                  gathered_bits = {6'b0, b[3:0]};
                  pending_bytes = PEND_TWO;
               end
            end
            PEND_ONE: begin
               owes          = 1'b1;
               code          = {gathered_bits, b[5:0]};
               pending_bytes = PEND_LEAD;
               gathered_bits = '0;
            end
            default: begin
               if (last) begin
                  owes          = 1'b1;
                  code          = QMARK_CODE;
                  pending_bytes = PEND_LEAD;
                  gathered_bits = '0;
               end else begin
                  gathered_bits = {gathered_bits[3:0], b[5:0]};
                  pending_bytes = PEND_ONE;
               end
            end
         endcase
         if (owes) begin
            owed_chars.push_back(code);
            if (code == QMARK_CODE) qmarks_owed++;
         end
      endfunction

      task check_char(input logic [15:0] code);
         logic [15:0] want;
         if (owed_chars.size() == 0) begin
            report($sformatf("char_code %h with nothing owed", code));
         end else begin
            want = owed_chars.pop_front();
            chars_checked++;
            if (code !== want)
               report($sformatf("char_code %h, expected %h", code, want));
         end
      endtask
   endclass

   logic clock;
   logic reset;

   ubsd_req_if req_bus();
   ubsd_rsp_if rsp_bus();

   utf8_byte_stream_decoder i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   char_scoreboard sb = new();

   // idling switch, long output hold-off and its trigger
   bit   idle_on      = 1'b1;
   bit   hold_rx_go   = 1'b0;
   logic hold_rx;
   int   rx_stall_left;

   localparam int NUM_BYTES     = 1150;
   localparam int HOLD_CYCLES   = 300;
   localparam int TAIL_CYCLES   = 8;
   localparam int LIMIT_CYCLES  = 200000;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // overall time limit
   initial begin
      #(2 * LIMIT_CYCLES);
      $display("timeout: %0d characters still owed", sb.owed_chars.size());
      $display("DONE: errors detected");
      $finish;
   end

   // long hold-off on the result side, counted here so the sender keeps offering
   initial begin
      hold_rx <= 1'b0;
      wait (hold_rx_go);
      @(posedge clock);
      hold_rx <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rx <= 1'b0;
   end

   // result side: check each transfer, then pick ready for the next edge
   initial begin
      rsp_bus.ready <= 1'b0;
      rx_stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready)
            sb.check_char(rsp_bus.char_code);
         if (hold_rx) begin
            rsp_bus.ready <= 1'b0;
         end else if (rx_stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            rx_stall_left--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            // start a burst of stalled cycles
            rsp_bus.ready <= 1'b0;
            rx_stall_left = $urandom_range(1, 13) - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // offer one byte, with an optional idle burst first; returns at its transfer
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 13);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.data_byte  <= b;
      req_bus.buffer_end <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_byte(b, last);
   endtask

   // stop offering and wait for every owed character
   task automatic drain_chars();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (sb.owed_chars.size() != 0) @(posedge clock);
   endtask

   // continuation byte: mostly 10xxxxxx, sometimes anything since the top bits are ignored
   function automatic logic [7:0] cont_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 7) != 0) b[7:6] = 2'b10;
      return b;
   endfunction

   // one random sequence: mostly well formed, some bad leads, truncations and noise
   task automatic send_random_sequence();
      ubsd_item_type seq[$];
      ubsd_item_type it;
      int            kind;
      int            n;
      logic          end_flag;
      kind     = $urandom_range(0, 9);
      end_flag = ($urandom_range(0, 7) == 0);
      case (kind)
         0, 1: begin
            it.data_byte  = 8'($urandom_range(0, 127));
            it.buffer_end = end_flag;
            seq.push_back(it);
         end
         2, 3: begin
            it.data_byte  = 8'hC0 | 8'($urandom_range(0, 31));
            it.buffer_end = 1'b0;
            seq.push_back(it);
            it.data_byte  = cont_byte();
            it.buffer_end = end_flag;
            seq.push_back(it);
         end
         4, 5, 6: begin
            it.data_byte  = 8'hE0 | 8'($urandom_range(0, 15));
            it.buffer_end = 1'b0;
            seq.push_back(it);
            it.data_byte  = cont_byte();
            seq.push_back(it);
            it.data_byte  = cont_byte();
            it.buffer_end = end_flag;
            seq.push_back(it);
         end
         7: begin
            // bad lead byte, from either illegal range
            if ($urandom_range(0, 1))
               it.data_byte = 8'h80 + 8'($urandom_range(0, 63));
            else
               it.data_byte = 8'hF0 + 8'($urandom_range(0, 15));
            it.buffer_end = end_flag;
            seq.push_back(it);
         end
         8: begin
            // buffer ends inside a sequence
            n = $urandom_range(0, 2);
            if (n == 0) begin
               it.data_byte  = 8'hC0 | 8'($urandom_range(0, 31));
               it.buffer_end = 1'b1;
               seq.push_back(it);
            end else begin
               it.data_byte  = 8'hE0 | 8'($urandom_range(0, 15));
               it.buffer_end = (n == 1);
               seq.push_back(it);
               if (n == 2) begin
                  it.data_byte  = cont_byte();
                  it.buffer_end = 1'b1;
                  seq.push_back(it);
               end
            end
         end
         default: begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               it.data_byte  = 8'($urandom_range(0, 255));
               it.buffer_end = 1'($urandom_range(0, 1));
               seq.push_back(it);
            end
         end
      endcase
      foreach (seq[i]) send_byte(seq[i].data_byte, seq[i].buffer_end);
   endtask

   // stimulus
   initial begin
      bit held;
      bit paused;
      held   = 1'b0;
      paused = 1'b0;
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.data_byte  <= '0;
      req_bus.buffer_end <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: ascii extremes, bad leads, full sequences, truncation
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hC0, 1'b0);   // smallest two-byte sequence
      send_byte(8'h80, 1'b0);
      send_byte(8'hDF, 1'b0);   // largest two-byte sequence
      send_byte(8'hBF, 1'b0);
      send_byte(8'hE0, 1'b0);   // smallest three-byte sequence
      send_byte(8'h80, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hEF, 1'b0);   // largest three-byte sequence
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hC5, 1'b1);   // buffer ends after a two-byte lead
      send_byte(8'hE5, 1'b1);   // buffer ends after a three-byte lead
      send_byte(8'hE5, 1'b0);   // buffer ends on the middle byte
      send_byte(8'h85, 1'b1);
      send_byte(8'hC3, 1'b0);   // buffer ends on a completing byte
      send_byte(8'hA9, 1'b1);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b1);
      send_byte(8'hC3, 1'b0);   // continuation top bits ignored
      send_byte(8'h69, 1'b0);

      // random part
      while (sb.bytes_seen < NUM_BYTES) begin
         if (!held && sb.bytes_seen >= 300) begin
            held       = 1'b1;
            hold_rx_go = 1'b1;
         end
         if (!paused && sb.bytes_seen >= 650) begin
            paused = 1'b1;
            drain_chars();
         end
         if (sb.bytes_seen >= 950) idle_on = 1'b0;
         send_random_sequence();
      end

      drain_chars();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.owed_chars.size() != 0)
         sb.report($sformatf("%0d characters never arrived", sb.owed_chars.size()));

      $display("summary: %0d bytes transferred, %0d characters checked, %0d of them '?'",
               sb.bytes_seen, sb.chars_checked, sb.qmarks_owed);
      $display("summary: one to three byte sequences, bad leads, truncation, long output hold");
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/ubsd_pkg.sv
rtl/ubsd_if.sv
rtl/ubsd_in_reg.sv
rtl/ubsd_decode.sv
rtl/ubsd_out_reg.sv
rtl/utf8_byte_stream_decoder.sv
test/tb.sv
